FILE: design/ptrm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptrm_pkg: shared types and constants of the pulse timestamp rpm meter
// Item structs, arithmetic request types, register decode and FSM states.
// ----------------------------------------------------------------------------
package ptrm_pkg;

    localparam int RING_DEPTH_DEF = 64;
    localparam int SLOT_W         = 6;
    localparam int SLOTS_LEFT_W   = 7;
    localparam int TIME_W         = 32;
    localparam int SPEED_W        = 32;
    localparam int CONST_W        = 48;
    localparam int NUM_W          = 64;
    localparam int APB_DATA_W     = 64;
    localparam int APB_ADDR_W     = 4;

    localparam logic [TIME_W-1:0]  MASK_WIDE   = 32'hFFFF_FFFF;
    localparam logic [TIME_W-1:0]  MASK_NARROW = 32'h0000_FFFF;
    localparam logic [SPEED_W-1:0] ONE_Q8      = 32'd256;

    localparam logic ACT_CAPTURE = 1'b0;
    localparam logic ACT_UPDATE  = 1'b1;

    localparam logic REG_SPEED_CONST = 1'b0;
    localparam logic REG_WIDE_TIMER  = 1'b1;

    typedef struct packed {
        logic                    action;
        logic [TIME_W-1:0]       pulse_time;
        logic [SLOT_W-1:0]       capture_slot;
        logic [SLOTS_LEFT_W-1:0] slots_left;
        logic [TIME_W-1:0]       timer_now;
    } t_in_item;

    typedef struct packed {
        logic [SPEED_W-1:0] speed_q8;
        logic               stopped;
    } t_out_item;

    typedef struct packed {
        logic               start;
        logic [NUM_W-1:0]   num;
        logic [TIME_W-1:0]  den;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [SPEED_W-1:0] quot;
    } t_div_rsp;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STAMP,
        ST_MUL,
        ST_DIV_SPEED,
        ST_ELAPSED,
        ST_DIV_CAP,
        ST_FINISH
    } t_state;

endpackage

FILE: design/ptrm_ring.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptrm_ring: capture timestamp ring
// One write port, one registered read port, zero sweep after reset.
// ----------------------------------------------------------------------------
module ptrm_ring #(
    parameter int RING_DEPTH = ptrm_pkg::RING_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_wr_en,
    input  logic [$clog2(RING_DEPTH)-1:0] i_wr_addr,
    input  logic [ptrm_pkg::TIME_W-1:0]   i_wr_data,
    input  logic                          i_rd_en,
    input  logic [$clog2(RING_DEPTH)-1:0] i_rd_addr,
    output logic [ptrm_pkg::TIME_W-1:0]   o_rd_data,
    output logic                          o_busy
);

    localparam int IDX_W = $clog2(RING_DEPTH);

    logic [ptrm_pkg::TIME_W-1:0] r_mem [RING_DEPTH];
    logic [ptrm_pkg::TIME_W-1:0] r_rd_data;
    logic                        r_clr_busy;
    logic [IDX_W-1:0]            r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + IDX_W'(1);
            if (r_clr_addr == IDX_W'(RING_DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_busy    = r_clr_busy;

endmodule

FILE: design/ptrm_sermul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptrm_sermul: bit-serial shift-add multiplier
// Multiplies the speed constant by the pulse count, one multiplier bit a cycle.
// ----------------------------------------------------------------------------
module ptrm_sermul #(
    parameter int MUL_W = 6
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [ptrm_pkg::CONST_W-1:0] i_mcand,
    input  logic [MUL_W-1:0]             i_mplier,
    output logic                         o_done,
    output logic [ptrm_pkg::NUM_W-1:0]   o_prod
);

    logic                       r_busy;
    logic [ptrm_pkg::NUM_W-1:0] r_acc;
    logic [ptrm_pkg::NUM_W-1:0] r_a;
    logic [MUL_W-1:0]           r_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && (r_b == '0)) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_a   <= ptrm_pkg::NUM_W'(i_mcand);
            r_b   <= i_mplier;
        end else if (r_busy && (r_b != '0)) begin
            r_acc <= r_b[0] ? (r_acc + r_a) : r_acc;
            r_a   <= {r_a[ptrm_pkg::NUM_W-2:0], 1'b0};
            r_b   <= r_b >> 1;
        end
    end

    assign o_done = r_busy && (r_b == '0);
    assign o_prod = r_acc;

endmodule

FILE: design/ptrm_serdiv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptrm_serdiv: bit-serial restoring divider, 64 by 32 bits
// One quotient bit a cycle; saturates to all ones on overflow or zero divisor.
// ----------------------------------------------------------------------------
module ptrm_serdiv (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ptrm_pkg::t_div_req i_req,
    output ptrm_pkg::t_div_rsp o_rsp
);

    localparam int QW = ptrm_pkg::SPEED_W;
    localparam int DW = ptrm_pkg::TIME_W;

    logic          r_busy;
    logic          r_done;
    logic [4:0]    r_cnt;
    logic [DW-1:0] r_rem;
    logic [QW-1:0] r_quo;
    logic [DW-1:0] r_den;

    logic [DW:0]   w_trial;
    logic [DW:0]   w_diff;
    logic          w_ge;
    logic          w_sat;

    assign w_trial = {r_rem, r_quo[QW-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_ge    = w_trial >= {1'b0, r_den};
    assign w_sat   = (i_req.den == '0) ||
                     (i_req.num[ptrm_pkg::NUM_W-1:QW] >= i_req.den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_cnt  <= '0;
                r_busy <= !w_sat;
                r_done <= w_sat;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_den <= i_req.den;
            if (w_sat) begin
                r_quo <= '1;
            end else begin
                r_rem <= i_req.num[ptrm_pkg::NUM_W-1:QW];
                r_quo <= i_req.num[QW-1:0];
            end
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
            r_quo <= {r_quo[QW-2:0], w_ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;

endmodule

FILE: design/pulse_timestamp_rpm_meter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pulse_timestamp_rpm_meter_unit: period-based tachometer
// Input transactions either store a pulse timestamp in the capture ring or
// request a speed update. Each update returns one output transaction with
// the speed in rpm (unsigned Q24.8, saturated) and a stopped flag.
// A capture is written to the ring as it is accepted. An update runs the
// control states, plus a shift-add multiply and a serial divide when new
// pulses give a valid period, plus a serial divide for the elapsed-time
// cap unless the elapsed time is zero or past the stop threshold. The
// serial divider, one quotient bit a cycle, dominates the update time.
// One transaction is in work at a time; a finished result sits in the
// output register, and the next input transaction is taken while it waits.
// If the receiver stalls and a second result is ready, the update holds
// until the output register frees up.
// After reset the ring is swept to zero, slot by slot, with input
// ready low; configuration writes are taken during the sweep.
// Registers: speed constant at 0x0, wide timer select at 0x8.
// ----------------------------------------------------------------------------
module pulse_timestamp_rpm_meter_unit #(
    parameter int RING_DEPTH = ptrm_pkg::RING_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  ptrm_pkg::t_in_item                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output ptrm_pkg::t_out_item                 o_out_data,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ptrm_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [ptrm_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [ptrm_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    localparam int IDX_W     = $clog2(RING_DEPTH);
    localparam int TAB_DEPTH = 2 ** ptrm_pkg::SLOTS_LEFT_W;
    localparam int TW        = ptrm_pkg::TIME_W;
    localparam int SW        = ptrm_pkg::SPEED_W;

    // config
    logic [ptrm_pkg::CONST_W-1:0] r_speed_const;
    logic                         r_wide;

    // control and model state
    ptrm_pkg::t_state  r_state;
    ptrm_pkg::t_state  n_state;
    logic [IDX_W-1:0]  r_read_pos;
    logic [TW-1:0]     r_anchor;
    logic [SW-1:0]     r_valid_speed;
    logic              r_out_valid;

    // payload
    logic [TW-1:0]       r_now;
    logic [IDX_W-1:0]    r_wpos;
    logic [IDX_W-1:0]    r_pulses;
    logic [TW-1:0]       r_delta;
    logic [SW-1:0]       r_speed;
    logic                r_stopped;
    ptrm_pkg::t_out_item r_out_data;

    logic [IDX_W-1:0] w_mod_tab [TAB_DEPTH];
    logic [IDX_W-1:0] w_slot_mod;
    logic [IDX_W-1:0] w_left_mod;
    logic [IDX_W-1:0] w_wpos;
    logic [IDX_W-1:0] w_pulses;
    logic [IDX_W-1:0] w_newest;
    logic [TW-1:0]    w_mask;
    logic [TW-1:0]    w_half;
    logic [TW-1:0]    w_rd_data;
    logic [TW-1:0]    w_delta;
    logic             w_delta_ok;
    logic [TW-1:0]    w_elapsed;
    logic             w_ring_busy;
    logic             w_accept;
    logic             w_out_free;
    logic             w_wr_en;
    logic             w_rd_en;
    logic             w_mul_start;
    logic             w_mul_done;
    logic [ptrm_pkg::NUM_W-1:0] w_prod;
    ptrm_pkg::t_div_req         w_div_req;
    ptrm_pkg::t_div_rsp         w_div_rsp;

    // slot reduction table
    for (genvar g = 0; g < TAB_DEPTH; g++) begin : g_mod_tab
        assign w_mod_tab[g] = IDX_W'(g % RING_DEPTH);
    end

    assign w_slot_mod = w_mod_tab[{1'b0, i_in_data.capture_slot}];
    assign w_left_mod = w_mod_tab[i_in_data.slots_left];
    assign w_wpos     = (w_left_mod == '0) ? '0 :
                        IDX_W'((IDX_W + 1)'(RING_DEPTH) - (IDX_W + 1)'(w_left_mod));
    assign w_pulses   = (w_wpos >= r_read_pos) ? (w_wpos - r_read_pos) :
                        IDX_W'((IDX_W + 1)'(w_wpos) + (IDX_W + 1)'(RING_DEPTH)
                               - (IDX_W + 1)'(r_read_pos));
    assign w_newest   = (w_wpos == '0) ? IDX_W'(RING_DEPTH - 1) : (w_wpos - IDX_W'(1));

    assign w_mask     = r_wide ? ptrm_pkg::MASK_WIDE : ptrm_pkg::MASK_NARROW;
    assign w_half     = w_mask >> 1;
    assign w_delta    = (w_rd_data - r_anchor) & w_mask;
    assign w_delta_ok = (w_delta != '0) && (w_delta < w_half);
    assign w_elapsed  = (r_now - r_anchor) & w_mask;

    assign o_in_ready = (r_state == ptrm_pkg::ST_IDLE) && !w_ring_busy;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    // config port
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_const <= '0;
            r_wide        <= 1'b1;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3])
                ptrm_pkg::REG_SPEED_CONST: r_speed_const <= pwdata[ptrm_pkg::CONST_W-1:0];
                ptrm_pkg::REG_WIDE_TIMER:  r_wide        <= pwdata[0];
                default:                   r_wide        <= r_wide;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3])
            ptrm_pkg::REG_SPEED_CONST: prdata = ptrm_pkg::APB_DATA_W'(r_speed_const);
            ptrm_pkg::REG_WIDE_TIMER:  prdata = ptrm_pkg::APB_DATA_W'(r_wide);
            default:                   prdata = '0;
        endcase
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ptrm_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        w_wr_en     = 1'b0;
        w_rd_en     = 1'b0;
        w_mul_start = 1'b0;
        w_div_req   = '0;
        unique case (r_state)
            ptrm_pkg::ST_IDLE: begin
                if (w_accept) begin
                    if (i_in_data.action == ptrm_pkg::ACT_CAPTURE) begin
                        w_wr_en = 1'b1;
                    end else if (w_pulses != '0) begin
                        w_rd_en = 1'b1;
                        n_state = ptrm_pkg::ST_STAMP;
                    end else begin
                        n_state = ptrm_pkg::ST_ELAPSED;
                    end
                end
            end
            ptrm_pkg::ST_STAMP: begin
                w_mul_start = w_delta_ok;
                n_state     = w_delta_ok ? ptrm_pkg::ST_MUL : ptrm_pkg::ST_ELAPSED;
            end
            ptrm_pkg::ST_MUL: begin
                if (w_mul_done) begin
                    w_div_req.start = 1'b1;
                    w_div_req.num   = w_prod;
                    w_div_req.den   = r_delta;
                    n_state         = ptrm_pkg::ST_DIV_SPEED;
                end
            end
            ptrm_pkg::ST_DIV_SPEED: begin
                if (w_div_rsp.done) begin
                    n_state = ptrm_pkg::ST_ELAPSED;
                end
            end
            ptrm_pkg::ST_ELAPSED: begin
                if (w_elapsed > w_half) begin
                    n_state = ptrm_pkg::ST_FINISH;
                end else if (w_elapsed != '0) begin
                    w_div_req.start = 1'b1;
                    w_div_req.num   = ptrm_pkg::NUM_W'(r_speed_const);
                    w_div_req.den   = w_elapsed;
                    n_state         = ptrm_pkg::ST_DIV_CAP;
                end else begin
                    n_state = ptrm_pkg::ST_FINISH;
                end
            end
            ptrm_pkg::ST_DIV_CAP: begin
                if (w_div_rsp.done) begin
                    n_state = ptrm_pkg::ST_FINISH;
                end
            end
            ptrm_pkg::ST_FINISH: begin
                if (w_out_free) begin
                    n_state = ptrm_pkg::ST_IDLE;
                end
            end
            default: n_state = ptrm_pkg::ST_IDLE;
        endcase
    end

    // tachometer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_read_pos    <= '0;
            r_anchor      <= '0;
            r_valid_speed <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (r_state == ptrm_pkg::ST_STAMP) begin
                r_anchor   <= w_rd_data;
                r_read_pos <= r_wpos;
            end
            if ((r_state == ptrm_pkg::ST_DIV_SPEED) && w_div_rsp.done) begin
                r_valid_speed <= w_div_rsp.quot;
            end
            if ((r_state == ptrm_pkg::ST_ELAPSED) && (w_elapsed > w_half)) begin
                r_valid_speed <= '0;
            end
            if ((r_state == ptrm_pkg::ST_FINISH) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_now    <= i_in_data.timer_now;
            r_wpos   <= w_wpos;
            r_pulses <= w_pulses;
        end
        if (r_state == ptrm_pkg::ST_STAMP) begin
            r_delta <= w_delta;
        end
        if (r_state == ptrm_pkg::ST_ELAPSED) begin
            if (w_elapsed > w_half) begin
                r_speed   <= '0;
                r_stopped <= 1'b1;
            end else begin
                r_speed   <= r_valid_speed;
                r_stopped <= 1'b0;
            end
        end
        if ((r_state == ptrm_pkg::ST_DIV_CAP) && w_div_rsp.done) begin
            r_speed <= (w_div_rsp.quot < r_valid_speed) ? w_div_rsp.quot : r_valid_speed;
        end
        if ((r_state == ptrm_pkg::ST_FINISH) && w_out_free) begin
            r_out_data.speed_q8 <= (r_speed < ptrm_pkg::ONE_Q8) ? '0 : r_speed;
            r_out_data.stopped  <= r_stopped;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    ptrm_ring #(
        .RING_DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_slot_mod),
        .i_wr_data (i_in_data.pulse_time),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_newest),
        .o_rd_data (w_rd_data),
        .o_busy    (w_ring_busy)
    );

    ptrm_sermul #(
        .MUL_W (IDX_W)
    ) u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_mul_start),
        .i_mcand  (r_speed_const),
        .i_mplier (r_pulses),
        .o_done   (w_mul_done),
        .o_prod   (w_prod)
    );

    ptrm_serdiv u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

endmodule
